// ===== rtl/acdc_pkg.sv =====
package acdc_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int WIN_LEN     = 5;
    localparam int SUM_W       = 35;
    localparam int ACC_W       = 44;
    localparam int COEF_W      = 9;
    localparam int LIM_W       = 16;
    localparam int DUTY_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int BIAS_SHIFT  = 10;
    localparam int SCALE_SHIFT = 17;
    localparam int COEF_SHIFT  = 8;
    localparam int KNEE_SHIFT  = 2;

    localparam logic signed [32:0] BIAS_SPAN = 33'sd1000000;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_HP_COEFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LP_COEFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_EN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN  = 3'd7;

    typedef logic signed [ACC_W-1:0] acc_t;

endpackage

// ===== rtl/acdc_ram.sv =====
module acdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/acdc_smul.sv =====
module acdc_smul #(
    parameter int AW = 44
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [AW-1:0]              a,
    input  logic [acdc_pkg::COEF_W-1:0]       b,
    output logic                              done,
    output logic signed [AW+acdc_pkg::COEF_W-1:0] p
);
    import acdc_pkg::*;

    localparam int PW = AW + COEF_W;

    logic signed [PW-1:0]         acc_reg;
    logic signed [PW-1:0]         mcand_reg;
    logic [COEF_W-1:0]            mult_reg;
    logic [$clog2(COEF_W)-1:0]    cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    // one multiplier bit per cycle, lsb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg   <= '0;
                mcand_reg <= PW'(a);
                mult_reg  <= b;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                if (mult_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg <= mcand_reg <<< 1;
                mult_reg  <= mult_reg >> 1;
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(COEF_W))'(COEF_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== rtl/acdc_div5.sv =====
module acdc_div5 #(
    parameter int W = 35
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] x,
    output logic                done,
    output logic signed [W-1:0] q
);
    import acdc_pkg::*;

    logic [W-1:0]           q_reg;
    logic [2:0]             rem_reg;
    logic [$clog2(W)-1:0]   cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic [3:0]             trial;
    logic                   qbit;

    // restoring division of the magnitude, one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, q_reg[W-1]};
        qbit  = (trial >= 4'(WIN_LEN));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg  <= x[W-1];
                q_reg    <= x[W-1] ? W'(-x) : W'(x);
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= qbit ? 3'(trial - 4'(WIN_LEN)) : trial[2:0];
                q_reg   <= {q_reg[W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(W))'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // truncation toward zero: sign put back on the magnitude quotient
    assign q    = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign done = done_reg;

endmodule

// ===== rtl/audio_conditioning_delay_chain.sv =====
// audio conditioning and delay chain
// one raw 32-bit microphone sample in on the s_ channel, one result out on the m_
// channel: pwm duty value plus the soft-limited sample stored in the delay line.
// settings arrive over the cfg_ channel (index, data), to be written while idle.
// a sequencer walks each item through the steps: window sum, a bit-serial
// divide by five, bias tracking, three one-pole filters and the delay mix,
// each multiply bit-serial in the shared serial multiplier; the seeding sample
// skips the window sum and divide. one item at a time: no new sample is taken
// until the sequencer is back in idle.
// the result sits in an output register; s_tready returns as soon as the
// sequencer is back in idle, even while that result still waits on m_tready.
// if the receiver stalls with a result pending, the next item stops at the
// final step until the output register frees.
// after reset (aresetn low, synchronous) all settings take their defaults, the
// filters and biases are cleared and the next sample seeds the window.
// the delay line memory is not cleared; entries are only mixed in once written.
module audio_conditioning_delay_chain #(
    parameter int DELAY_DEPTH = 32768,
    parameter int PWM_PERIOD  = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // raw_sample[31:0]
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // pwm_duty[11:0], conditioned_sample[27:12], zero[31:28]
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import acdc_pkg::*;

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int FC_W = $clog2(DELAY_DEPTH + 2);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SUM   = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_DIVW  = 5'd3;
    localparam logic [4:0] S_BIAS  = 5'd4;
    localparam logic [4:0] S_CHK   = 5'd5;
    localparam logic [4:0] S_AUD   = 5'd6;
    localparam logic [4:0] S_HP    = 5'd7;
    localparam logic [4:0] S_HPW   = 5'd8;
    localparam logic [4:0] S_FILT  = 5'd9;
    localparam logic [4:0] S_LP1   = 5'd10;
    localparam logic [4:0] S_LP1W  = 5'd11;
    localparam logic [4:0] S_LP2   = 5'd12;
    localparam logic [4:0] S_LP2W  = 5'd13;
    localparam logic [4:0] S_LIM1  = 5'd14;
    localparam logic [4:0] S_LIM2  = 5'd15;
    localparam logic [4:0] S_WR    = 5'd16;
    localparam logic [4:0] S_RD    = 5'd17;
    localparam logic [4:0] S_RDW   = 5'd18;
    localparam logic [4:0] S_MIXD  = 5'd19;
    localparam logic [4:0] S_MIXDW = 5'd20;
    localparam logic [4:0] S_MIXW  = 5'd21;
    localparam logic [4:0] S_MIXWW = 5'd22;
    localparam logic [4:0] S_CLMP  = 5'd23;
    localparam logic [4:0] S_OUT   = 5'd24;

    logic [4:0] state_reg;

    // configuration registers
    logic [COEF_W-1:0]     hp_coeff_reg;
    logic [COEF_W-1:0]     lp_coeff_reg;
    logic [14:0]           in_limit_reg;
    logic [10:0]           out_limit_reg;
    logic [COEF_W-1:0]     dry_gain_reg;
    logic [COEF_W-1:0]     wet_gain_reg;
    logic                  delay_en_reg;
    logic [15:0]           delay_len_reg;

    // datapath state
    logic signed [SAMPLE_W-1:0] window_reg [WIN_LEN];
    logic [2:0]                 slot_reg;
    logic [2:0]                 idx_reg;
    logic                       first_reg;
    logic signed [SAMPLE_W-1:0] static_reg;
    logic signed [SAMPLE_W-1:0] drift_reg;
    logic signed [SAMPLE_W-1:0] cur_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    acc_t                       audio_reg;
    acc_t                       filt_reg;
    acc_t                       hp_reg;
    acc_t                       lp1_reg;
    acc_t                       lp2_reg;
    acc_t                       ex_reg;
    acc_t                       mix_reg;
    logic                       over_reg;
    logic                       under_reg;
    logic signed [LIM_W-1:0]    lim_reg;
    logic signed [LIM_W-1:0]    wet_reg;
    logic [AW-1:0]              wp_reg;
    logic [FC_W-1:0]            fill_reg;
    logic [AW:0]                slot_raw_reg;
    logic                       mix_en_reg;

    // output register
    logic                       m_valid_reg;
    logic [DUTY_W-1:0]          duty_reg;
    logic [LIM_W-1:0]           cond_reg;

    // shared multiplier and the divider
    logic                       mul_start;
    acc_t                       mul_a;
    logic [COEF_W-1:0]          mul_b;
    logic                       mul_done;
    logic signed [ACC_W+COEF_W-1:0] mul_p;
    acc_t                       prod_sh;
    logic                       div_start;
    logic                       div_done;
    logic signed [SUM_W-1:0]    div_q;

    // memory port
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [LIM_W-1:0]           ram_rdata;
    logic [AW-1:0]              rd_addr;

    // combinational helpers
    logic [FC_W-1:0]            d_eff;
    logic [FC_W-1:0]            fill_new;
    logic [AW-1:0]              wp_new;
    logic signed [32:0]         bias_diff;
    logic signed [32:0]         bias_chk;
    acc_t                       knee;
    acc_t                       scaled;
    acc_t                       lim_t;
    acc_t                       duty_sum;
    acc_t                       olim;
    logic                       out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign prod_sh = ACC_W'(mul_p >>> COEF_SHIFT);
    assign knee    = ACC_W'($signed({1'b0, in_limit_reg}));
    assign olim    = ACC_W'($signed({1'b0, out_limit_reg}));
    assign scaled  = lp2_reg >>> SCALE_SHIFT;

    // effective delay: zero or beyond the depth means the whole depth
    always_comb begin
        if (delay_len_reg == 16'd0 || 32'(delay_len_reg) > 32'(DELAY_DEPTH)) begin
            d_eff = FC_W'(DELAY_DEPTH);
        end else begin
            d_eff = FC_W'(delay_len_reg);
        end
        fill_new = (fill_reg == FC_W'(DELAY_DEPTH + 1)) ? fill_reg : fill_reg + 1'b1;
        wp_new   = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        rd_addr  = (slot_raw_reg >= (AW+1)'(DELAY_DEPTH))
                 ? AW'(slot_raw_reg - (AW+1)'(DELAY_DEPTH)) : AW'(slot_raw_reg);
        bias_diff = 33'(cur_reg) - 33'(drift_reg);
        bias_chk  = 33'(drift_reg) - 33'(cur_reg);
    end

    // soft limiter knee and pwm duty sum
    always_comb begin
        if (over_reg) begin
            lim_t = knee + (ex_reg >>> KNEE_SHIFT);
        end else if (under_reg) begin
            lim_t = -knee + (ex_reg >>> KNEE_SHIFT);
        end else begin
            lim_t = scaled;
        end
        duty_sum = mix_reg + ACC_W'(PWM_PERIOD / 2);
    end

    // multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_HP: begin
                mul_start = 1'b1;
                mul_a     = audio_reg - hp_reg;
                mul_b     = hp_coeff_reg;
            end
            S_LP1: begin
                mul_start = 1'b1;
                mul_a     = filt_reg - lp1_reg;
                mul_b     = lp_coeff_reg;
            end
            S_LP2: begin
                mul_start = 1'b1;
                mul_a     = lp1_reg - lp2_reg;
                mul_b     = lp_coeff_reg;
            end
            S_MIXD: begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(lim_reg);
                mul_b     = dry_gain_reg;
            end
            S_MIXW: begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(wet_reg);
                mul_b     = wet_gain_reg;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == S_DIV);
    assign ram_we    = (state_reg == S_WR);
    assign ram_addr  = (state_reg == S_WR) ? wp_reg : rd_addr;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_coeff_reg  <= 9'd2;
            lp_coeff_reg  <= 9'd128;
            in_limit_reg  <= 15'd800;
            out_limit_reg <= 11'd1000;
            dry_gain_reg  <= 9'd256;
            wet_gain_reg  <= 9'd128;
            delay_en_reg  <= 1'b0;
            delay_len_reg <= 16'd16384;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HP_COEFF:  hp_coeff_reg  <= cfg_data[8:0];
                REG_LP_COEFF:  lp_coeff_reg  <= cfg_data[8:0];
                REG_IN_LIMIT:  in_limit_reg  <= cfg_data[14:0];
                REG_OUT_LIMIT: out_limit_reg <= cfg_data[10:0];
                REG_DRY_GAIN:  dry_gain_reg  <= cfg_data[8:0];
                REG_WET_GAIN:  wet_gain_reg  <= cfg_data[8:0];
                REG_DELAY_EN:  delay_en_reg  <= cfg_data[0];
                REG_DELAY_LEN: delay_len_reg <= cfg_data;
                default:       delay_en_reg  <= delay_en_reg;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            first_reg   <= 1'b1;
            slot_reg    <= '0;
            idx_reg     <= '0;
            static_reg  <= '0;
            drift_reg   <= '0;
            hp_reg      <= '0;
            lp1_reg     <= '0;
            lp2_reg     <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < WIN_LEN; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            // pending result taken and no new one loaded this cycle
            if (m_valid_reg && m_tready && !(state_reg == S_OUT && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        slot_reg <= (slot_reg == 3'(WIN_LEN - 1)) ? '0 : slot_reg + 1'b1;
                        if (first_reg) begin
                            // first sample seeds window and both biases
                            for (int i = 0; i < WIN_LEN; i++) begin
                                window_reg[i] <= $signed(s_tdata);
                            end
                            static_reg <= $signed(s_tdata);
                            drift_reg  <= $signed(s_tdata);
                            cur_reg    <= $signed(s_tdata);
                            first_reg  <= 1'b0;
                            state_reg  <= S_BIAS;
                        end else begin
                            window_reg[slot_reg] <= $signed(s_tdata);
                            sum_reg   <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    sum_reg <= sum_reg + SUM_W'(window_reg[idx_reg]);
                    if (idx_reg == 3'(WIN_LEN - 1)) begin
                        state_reg <= S_DIV;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DIV: begin
                    state_reg <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        cur_reg   <= SAMPLE_W'(div_q);
                        state_reg <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    drift_reg <= SAMPLE_W'(33'(drift_reg) + (bias_diff >>> BIAS_SHIFT));
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    // drift bias too far from the signal: fall back to static bias
                    if (bias_chk > BIAS_SPAN || bias_chk < -BIAS_SPAN) begin
                        drift_reg <= static_reg;
                    end
                    state_reg <= S_AUD;
                end
                S_AUD: begin
                    audio_reg <= ACC_W'(cur_reg) - ACC_W'(drift_reg);
                    state_reg <= S_HP;
                end
                S_HP: begin
                    state_reg <= S_HPW;
                end
                S_HPW: begin
                    if (mul_done) begin
                        hp_reg    <= hp_reg + prod_sh;
                        state_reg <= S_FILT;
                    end
                end
                S_FILT: begin
                    filt_reg  <= audio_reg - hp_reg;
                    state_reg <= S_LP1;
                end
                S_LP1: begin
                    state_reg <= S_LP1W;
                end
                S_LP1W: begin
                    if (mul_done) begin
                        lp1_reg   <= lp1_reg + prod_sh;
                        state_reg <= S_LP2;
                    end
                end
                S_LP2: begin
                    state_reg <= S_LP2W;
                end
                S_LP2W: begin
                    if (mul_done) begin
                        lp2_reg   <= lp2_reg + prod_sh;
                        state_reg <= S_LIM1;
                    end
                end
                S_LIM1: begin
                    over_reg  <= scaled > knee;
                    under_reg <= scaled < -knee;
                    ex_reg    <= (scaled > knee) ? scaled - knee : scaled + knee;
                    state_reg <= S_LIM2;
                end
                S_LIM2: begin
                    if (lim_t > ACC_W'(32767)) begin
                        lim_reg <= 16'sd32767;
                    end else if (lim_t < -ACC_W'(32768)) begin
                        lim_reg <= 16'sh8000;
                    end else begin
                        lim_reg <= LIM_W'(lim_t);
                    end
                    state_reg <= S_WR;
                end
                S_WR: begin
                    wp_reg       <= wp_new;
                    fill_reg     <= fill_new;
                    slot_raw_reg <= (AW+1)'(32'(wp_new) + 32'(DELAY_DEPTH) - 32'(d_eff));
                    mix_en_reg   <= delay_en_reg && (fill_new > d_eff);
                    state_reg    <= S_RD;
                end
                S_RD: begin
                    state_reg <= S_RDW;
                end
                S_RDW: begin
                    wet_reg <= $signed(ram_rdata);
                    if (mix_en_reg) begin
                        state_reg <= S_MIXD;
                    end else begin
                        mix_reg   <= ACC_W'(lim_reg);
                        state_reg <= S_CLMP;
                    end
                end
                S_MIXD: begin
                    state_reg <= S_MIXDW;
                end
                S_MIXDW: begin
                    if (mul_done) begin
                        mix_reg   <= prod_sh;
                        state_reg <= S_MIXW;
                    end
                end
                S_MIXW: begin
                    state_reg <= S_MIXWW;
                end
                S_MIXWW: begin
                    if (mul_done) begin
                        mix_reg   <= mix_reg + prod_sh;
                        state_reg <= S_CLMP;
                    end
                end
                S_CLMP: begin
                    if (mix_reg > olim) begin
                        mix_reg <= olim;
                    end else if (mix_reg < -olim) begin
                        mix_reg <= -olim;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // wait for the output register to free, then recentre onto pwm
                    if (out_free) begin
                        if (duty_sum < 0) begin
                            duty_reg <= '0;
                        end else if (duty_sum > ACC_W'(PWM_PERIOD)) begin
                            duty_reg <= DUTY_W'(PWM_PERIOD);
                        end else begin
                            duty_reg <= DUTY_W'(duty_sum);
                        end
                        cond_reg    <= lim_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, cond_reg, duty_reg};

    acdc_smul #(
        .AW (ACC_W)
    ) u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    acdc_div5 #(
        .W (SUM_W)
    ) u_div5 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .x       (sum_reg),
        .done    (div_done),
        .q       (div_q)
    );

    acdc_ram #(
        .WIDTH (LIM_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (lim_reg),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // an accepted item always starts the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("sequencer did not leave idle after input transfer");

    // write count never passes its saturation point
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FC_W'(DELAY_DEPTH + 1))
        else $error("fill count beyond saturation");

    // read address of the delayed sample stays inside the memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (32'(rd_addr) < 32'(DELAY_DEPTH)))
        else $error("delay read address out of range");

    // a result is loaded only when the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !out_free) |=> (state_reg == S_OUT))
        else $error("result overwrote a pending output");

    // mix path is taken only when delay is enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MIXD) |-> delay_en_reg)
        else $error("delay mix taken while disabled");
`endif

endmodule

// ===== verif/tb_audio_conditioning_delay_chain.sv =====
module tb_audio_conditioning_delay_chain;
    import acdc_pkg::*;

    localparam int DEPTH  = 32768;
    localparam int PERIOD = 2048;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // raw_sample[31:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pwm_duty[11:0], conditioned_sample[27:12], zero[31:28]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    audio_conditioning_delay_chain #(.DELAY_DEPTH(DEPTH), .PWM_PERIOD(PERIOD)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [11:0]        duty;
        logic signed [15:0] cond;
    } duty_pair_t;

    // predictor settings
    longint hp_k, lp_k, knee_lim, out_lim, dry_k, wet_k, dly_en, dly_len;
    // predictor state, held exact
    longint window_q [WIN_LEN];
    int     slot_q;
    bit     seed_pending;
    longint fixed_bias, track_bias, hp_acc, lp_one, lp_two;
    logic signed [15:0] echo_mem [DEPTH];
    int     wr_ptr, written;

    duty_pair_t duty_queue[$];
    int     mismatches;
    int     idle_in_pct, stall_pct;
    int     n_items;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint pole(longint acc, longint tgt, longint k);
        return acc + floor_sh((tgt - acc) * k, COEF_SHIFT);
    endfunction

    task automatic reset_model();
        hp_k = 2; lp_k = 128; knee_lim = 800; out_lim = 1000;
        dry_k = 256; wet_k = 128; dly_en = 0; dly_len = 16384;
        foreach (window_q[i]) window_q[i] = 0;
        slot_q = 0; seed_pending = 1;
        fixed_bias = 0; track_bias = 0; hp_acc = 0; lp_one = 0; lp_two = 0;
        wr_ptr = 0; written = 0;
    endtask

    task automatic model_setting(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        case (idx)
            REG_HP_COEFF:  hp_k = v[8:0];
            REG_LP_COEFF:  lp_k = v[8:0];
            REG_IN_LIMIT:  knee_lim = v[14:0];
            REG_OUT_LIMIT: out_lim = v[10:0];
            REG_DRY_GAIN:  dry_k = v[8:0];
            REG_WET_GAIN:  wet_k = v[8:0];
            REG_DELAY_EN:  dly_en = v[0];
            REG_DELAY_LEN: dly_len = v;
            default: ;
        endcase
    endtask

    function automatic duty_pair_t condition_sample(logic signed [31:0] raw);
        longint smp, cur, sum, aud, filt, sc, lim, mix;
        longint d;
        duty_pair_t r;
        smp = raw;
        window_q[slot_q] = smp;
        slot_q = (slot_q + 1) % WIN_LEN;
        if (seed_pending) begin
            foreach (window_q[i]) window_q[i] = smp;
            fixed_bias = smp; track_bias = smp; cur = smp; seed_pending = 0;
        end else begin
            sum = 0;
            foreach (window_q[i]) sum += window_q[i];
            cur = sum / WIN_LEN;   // truncates toward zero
        end
        track_bias += floor_sh(cur - track_bias, BIAS_SHIFT);
        if (track_bias > cur + 1000000 || track_bias < cur - 1000000)
            track_bias = fixed_bias;
        aud = cur - track_bias;
        hp_acc = pole(hp_acc, aud, hp_k);
        filt = aud - hp_acc;
        lp_one = pole(lp_one, filt, lp_k);
        lp_two = pole(lp_two, lp_one, lp_k);
        sc = floor_sh(lp_two, SCALE_SHIFT);
        lim = sc;
        if (lim > knee_lim) lim = knee_lim + floor_sh(lim - knee_lim, KNEE_SHIFT);
        else if (lim < -knee_lim) lim = -knee_lim + floor_sh(lim + knee_lim, KNEE_SHIFT);
        lim = clampv(lim, -32768, 32767);
        echo_mem[wr_ptr] = 16'(lim);
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (written < DEPTH + 1) written++;
        d = dly_len;
        if (d == 0 || d > DEPTH) d = DEPTH;
        mix = lim;
        if (dly_en != 0 && written > d)
            mix = floor_sh(lim * dry_k, COEF_SHIFT)
                + floor_sh(longint'(echo_mem[(wr_ptr + DEPTH - d) % DEPTH]) * wet_k,
                           COEF_SHIFT);
        mix = clampv(mix, -out_lim, out_lim);
        r.duty = 12'(clampv(mix + PERIOD / 2, 0, PERIOD));
        r.cond = 16'(lim);
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stall, compare against oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (duty_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    duty_pair_t e;
                    e = duty_queue.pop_front();
                    if (m_tdata[11:0] !== e.duty || m_tdata[27:12] !== e.cond
                        || m_tdata[31:28] !== 4'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: duty exp %0d got %0d, sample exp %0d got %0d",
                                     e.duty, m_tdata[11:0], e.cond,
                                     $signed(m_tdata[27:12]));
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays high after the transfer; the caller drops it after the last write
    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        model_setting(idx, v);
    endtask

    // push one sample: expectation recorded at the transfer edge
    task automatic send_sample(logic [31:0] raw);
        while ($urandom_range(99) < idle_in_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= raw;
        do @(posedge aclk); while (!s_tready);
        duty_queue.push_back(condition_sample(raw));
        n_items++;
    endtask

    task automatic check_fixed(logic [31:0] raw, int duty_exp, int cond_exp);
        duty_pair_t p;
        send_sample(raw);
        p = duty_queue[$];
        if (p.duty != duty_exp || p.cond != cond_exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("predictor disagrees on directed row: exp %0d/%0d", duty_exp, cond_exp);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (duty_queue.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // directed rows: raw sample, and typed expectation where obvious (-1 = predictor only)
    typedef struct { logic [31:0] raw; int duty; int cond; } row_t;
    row_t rows[] = '{
        '{32'h8000_0000, 1024, 0},     // seeding sample: no signal after bias removal
        '{32'h8000_0000, 1024, 0},
        '{32'h7FFF_FFFF, -1, -1},      // full-scale step
        '{32'h7FFF_FFFF, -1, -1},
        '{32'h7FFF_FFFF, -1, -1},
        '{32'h8000_0000, -1, -1},
        '{32'h0000_0000, -1, -1},
        '{32'hFFFF_FFFF, -1, -1},
        '{32'h0000_0001, -1, -1},
        '{32'h7FFF_FFFF, -1, -1},
        '{32'h8000_0000, -1, -1},
        '{32'h7FFF_FFFF, -1, -1},
        '{32'h8000_0000, -1, -1},
        '{32'h5555_5555, -1, -1},
        '{32'hAAAA_AAAA, -1, -1}
    };

    logic [CFG_IDX_W-1:0] reg_list [8] = '{REG_HP_COEFF, REG_LP_COEFF, REG_IN_LIMIT,
        REG_OUT_LIMIT, REG_DRY_GAIN, REG_WET_GAIN, REG_DELAY_EN, REG_DELAY_LEN};

    // random sample: mostly a swinging tone with noise, some full-range noise
    function automatic logic [31:0] pick_sample(int k);
        int amp;
        amp = (k % 3 == 0) ? 32'h4000_0000 : 32'h0100_0000;
        if ($urandom_range(9) == 0) return $urandom;
        return ((k / 4) % 2) ? amp + $urandom_range(65535) : -amp - $urandom_range(65535);
    endfunction

    initial begin
        int phase;
        aresetn = 0; s_tvalid = 0; s_tdata = 0;
        cfg_valid = 0; cfg_index = REG_HP_COEFF; cfg_data = 0;
        mismatches = 0; idle_in_pct = 0; stall_pct = 0; n_items = 0;
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with default settings
        foreach (rows[i]) begin
            if (rows[i].duty >= 0) check_fixed(rows[i].raw, rows[i].duty, rows[i].cond);
            else send_sample(rows[i].raw);
        end
        wait_idle();

        // short delay with limits at their extremes, coefficients at unity
        write_setting(REG_DELAY_EN, 16'd1);
        write_setting(REG_DELAY_LEN, 16'd1);
        write_setting(REG_HP_COEFF, 16'd256);
        write_setting(REG_LP_COEFF, 16'd256);
        write_setting(REG_IN_LIMIT, 16'd0);
        write_setting(REG_OUT_LIMIT, 16'd2047);
        write_setting(REG_DRY_GAIN, 16'd0);
        write_setting(REG_WET_GAIN, 16'd256);
        cfg_valid <= 1'b0;
        for (int k = 0; k < 6; k++) send_sample(k[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
        wait_idle();

        // random phases, each with fresh settings and idling pattern
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_in_pct = 0;  stall_pct = 0;  end
                1: begin idle_in_pct = 75; stall_pct = 0;  end
                2: begin idle_in_pct = 0;  stall_pct = 75; end
                default: begin idle_in_pct = 17; stall_pct = 17; end
            endcase
            foreach (reg_list[r]) begin
                logic [15:0] v;
                case (reg_list[r])
                    REG_DELAY_EN:  v = 16'($urandom_range(3) != 0);
                    REG_DELAY_LEN: v = (phase == 5) ? 16'd0 :
                                       (phase == 6) ? 16'hFFFF :
                                       (phase == 7) ? 16'd32768 : 16'($urandom_range(1, 12));
                    REG_IN_LIMIT:  v = (phase == 3) ? 16'h7FFF : 16'($urandom_range(0, 2000));
                    REG_OUT_LIMIT: v = (phase == 3) ? 16'd0 : 16'($urandom_range(0, 2047));
                    default:       v = (phase == 2) ? 16'h01FF : 16'($urandom_range(0, 256));
                endcase
                // phase four pushes full random words to toggle unused bits
                if (phase == 4) v = 16'($urandom);
                write_setting(reg_list[r], v);
            end
            cfg_valid <= 1'b0;
            for (int k = 0; k < 34; k++) send_sample(pick_sample(k));
            wait_idle();
        end

        idle_in_pct = 0; stall_pct = 0;
        wait_idle();
        if (mismatches == 0 && duty_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/acdc_pkg.sv
rtl/acdc_ram.sv
rtl/acdc_smul.sv
rtl/acdc_div5.sv
rtl/audio_conditioning_delay_chain.sv
verif/tb_audio_conditioning_delay_chain.sv
